/* src/assert_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock and held off during reset.
`define SPCF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clock and held off during reset.
`define SPCF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* src/spcf_pkg.sv */
// Types and constants of the prefixed command frame parser.
`timescale 1ns / 1ps
package spcf_pkg;

   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_END     = 3'd1;
   localparam logic [2:0] KIND_POP     = 3'd2;
   localparam logic [2:0] KIND_READ    = 3'd3;
   localparam logic [2:0] KIND_RELEASE = 3'd4;

   localparam logic [1:0] RES_SUMMARY = 2'd0;
   localparam logic [1:0] RES_COMMAND = 2'd1;
   localparam logic [1:0] RES_STAGED  = 2'd2;

   localparam logic [7:0] SYNC_BYTE  = 8'hCC;
   localparam logic [7:0] CMD_BYTE   = 8'hDD;
   localparam logic [7:0] SUB_BYTE   = 8'hDE;
   localparam logic [7:0] SUB_GROUPS = 8'h20;
   localparam logic [7:0] SUB_BLOCKS = 8'h21;

   localparam int CMD_FRAME_LEN = 9;
   localparam int SUB_OVERHEAD  = 7;
   // Reciprocal of six scaled by 2^18, exact for 16-bit lengths.
   localparam logic [15:0] RECIP_SIX = 16'hAAAB;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WSTART,
      ST_WHDR,
      ST_WEVAL,
      ST_WSUM,
      ST_WCOPY,
      ST_WDONE,
      ST_POP,
      ST_RDWAIT,
      ST_RDOUT
   } state_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  cmd_id;
      logic [7:0]  cmd_index;
      logic [31:0] cmd_value;
      logic        queue_empty;
      logic [4:0]  frames_queued;
      logic [31:0] drops_total;
      logic        subscribe_staged;
      logic [8:0]  subscribe_length;
      logic [7:0]  staged_byte;
   } rsp_type;

endpackage

/* src/spcf_if.sv */
// Handshake interfaces of the request and response channels.
`timescale 1ns / 1ps
interface spcf_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data_byte;
   logic [7:0] read_index;
   modport source (output valid, kind, data_byte, read_index, input ready);
   modport sink (input valid, kind, data_byte, read_index, output ready);
endinterface

interface spcf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  cmd_id;
   logic [7:0]  cmd_index;
   logic [31:0] cmd_value;
   logic        queue_empty;
   logic [4:0]  frames_queued;
   logic [31:0] drops_total;
   logic        subscribe_staged;
   logic [8:0]  subscribe_length;
   logic [7:0]  staged_byte;
   modport source (output valid, result_kind, cmd_id, cmd_index, cmd_value, queue_empty,
                   frames_queued, drops_total, subscribe_staged, subscribe_length,
                   staged_byte, input ready);
   modport sink (input valid, result_kind, cmd_id, cmd_index, cmd_value, queue_empty,
                 frames_queued, drops_total, subscribe_staged, subscribe_length,
                 staged_byte, output ready);
endinterface

/* src/sync_prefixed_command_frame_parser.sv */
// Top level of the prefixed command frame parser with its walk sequencer.
//
//   channel   ports      direction  carries
//   request   req_chan   in         kind, data_byte, read_index
//   response  rsp_chan   out        one result beat per end, pop or read
//   control   csr_*      in         subscribe enable
//
// A data byte or release beat is taken in idle; a pop passes through the pop state,
// a staged read through the read wait and read out states. The end-of-burst walk
// reads the single mailbox port one byte at a time: nine bytes per header position, plus a
// check pass over each well-formed subscribe frame that fits and a copy pass when it is staged.
// Reset is synchronous; the mailbox, queue and stage memories are not cleared.
// A result waits in the output register; the block stalls only to load it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sync_prefixed_command_frame_parser #(
   parameter int MAILBOX_DEPTH = 256,
   parameter int STAGE_DEPTH   = 256,
   parameter int QUEUE_DEPTH   = 16
) (
   input  logic              clock,
   input  logic              reset,
   spcf_req_if.sink          req_chan,
   spcf_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   localparam int MAW = $clog2(MAILBOX_DEPTH);
   localparam int CW  = $clog2(MAILBOX_DEPTH + 1);
   localparam int SAW = $clog2(STAGE_DEPTH);
   localparam int SW  = $clog2(STAGE_DEPTH + 1);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int PW  = ((CW > SW) ? CW : SW) + 1;
   localparam int CMD_HDR_N = spcf_pkg::CMD_FRAME_LEN;

   spcf_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [SW-1:0]  k_ff, k_in;
   logic           phase_ff, phase_in;
   logic [7:0]     hdr_ff [CMD_HDR_N];
   logic [7:0]     hdr_in [CMD_HDR_N];
   logic [SW-1:0]  flen_ff, flen_in;
   logic [7:0]     x_ff, x_in;
   logic [QW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [31:0]    drops_ff, drops_in;
   logic [4:0]     queued_ff, queued_in;
   logic [SW-1:0]  st_len_ff, st_len_in;
   logic           pend_ff, pend_in;
   logic           sub_en_ff;
   logic [SAW-1:0] st_raddr_ff, st_raddr_in;
   logic           st_rok_ff, st_rok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   spcf_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]  mb_mem [MAILBOX_DEPTH];
   logic [7:0]  mb_q_ff;
   logic [47:0] q_mem [QUEUE_DEPTH];
   logic [47:0] q_q_ff;
   logic [7:0]  st_mem [STAGE_DEPTH];
   logic [7:0]  st_q_ff;

   logic           accept, out_free, out_ld, mb_we, q_we, st_we;
   logic [MAW-1:0] mb_raddr;
   logic [15:0]    plen;
   logic [31:0]    prod;
   logic [15:0]    r6;
   logic           ok21, ok6, len_small, sub_ok, is_sub, is_cmd, cmd_ok, fits, full;
   logic [16:0]    flen17;
   logic [SW-1:0]  flen_w;
   logic [QW-1:0]  head_nxt, tail_nxt;
   logic [7:0]     cmd_x;
   logic           last_byte;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign mb_raddr = MAW'(PW'(pos_ff) + PW'(k_ff));

   assign plen      = {hdr_ff[3], hdr_ff[4]};
   assign prod      = 32'(plen) * 32'(spcf_pkg::RECIP_SIX);
   assign r6        = plen - 16'(prod[31:18] * 14'd6);
   assign ok6       = (r6 == 16'd0);
   assign ok21      = (plen >= 16'd3) && ((plen[2:0] - 3'd3) == 3'd0);
   assign len_small = (17'(plen) <= 17'(STAGE_DEPTH - spcf_pkg::SUB_OVERHEAD));
   assign sub_ok    = len_small && (((hdr_ff[2] == spcf_pkg::SUB_BLOCKS) && ok21) ||
                                    ((hdr_ff[2] == spcf_pkg::SUB_GROUPS) && ok6));
   assign flen17    = 17'(plen) + 17'(spcf_pkg::SUB_OVERHEAD);
   assign flen_w    = SW'(flen17);
   assign fits      = (PW'(pos_ff) + PW'(flen_w)) <= PW'(count_ff);
   assign is_sub    = sub_en_ff && (hdr_ff[0] == spcf_pkg::SYNC_BYTE) &&
                      (hdr_ff[1] == spcf_pkg::SUB_BYTE);
   assign is_cmd    = (hdr_ff[0] == spcf_pkg::SYNC_BYTE) && (hdr_ff[1] == spcf_pkg::CMD_BYTE);
   assign cmd_x     = hdr_ff[2] ^ hdr_ff[3] ^ hdr_ff[4] ^ hdr_ff[5] ^ hdr_ff[6] ^ hdr_ff[7];
   assign cmd_ok    = (cmd_x == hdr_ff[8]);
   assign head_nxt  = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_nxt  = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign full      = (head_nxt == tail_ff);
   assign last_byte = (k_ff == flen_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spcf_pkg::ST_IDLE: begin
            if (accept && req_chan.kind == spcf_pkg::KIND_END) state_in = spcf_pkg::ST_WSTART;
            if (accept && req_chan.kind == spcf_pkg::KIND_POP) state_in = spcf_pkg::ST_POP;
            if (accept && req_chan.kind == spcf_pkg::KIND_READ) state_in = spcf_pkg::ST_RDWAIT;
         end
         spcf_pkg::ST_WSTART: begin
            if ((PW'(pos_ff) + PW'(CMD_HDR_N)) > PW'(count_ff)) state_in = spcf_pkg::ST_WDONE;
            else state_in = spcf_pkg::ST_WHDR;
         end
         spcf_pkg::ST_WHDR: begin
            if (phase_ff && k_ff == SW'(CMD_HDR_N - 1)) state_in = spcf_pkg::ST_WEVAL;
         end
         spcf_pkg::ST_WEVAL: begin
            priority if (is_sub && sub_ok && !fits) state_in = spcf_pkg::ST_WDONE;
            else if (is_sub && sub_ok) state_in = spcf_pkg::ST_WSUM;
            else state_in = spcf_pkg::ST_WSTART;
         end
         spcf_pkg::ST_WSUM: begin
            if (phase_ff && last_byte) begin
               if ((x_ff == mb_q_ff) && !pend_ff) state_in = spcf_pkg::ST_WCOPY;
               else state_in = spcf_pkg::ST_WSTART;
            end
         end
         spcf_pkg::ST_WCOPY: begin
            if (phase_ff && last_byte) state_in = spcf_pkg::ST_WSTART;
         end
         spcf_pkg::ST_WDONE, spcf_pkg::ST_POP, spcf_pkg::ST_RDOUT: begin
            if (out_free) state_in = spcf_pkg::ST_IDLE;
         end
         spcf_pkg::ST_RDWAIT: state_in = spcf_pkg::ST_RDOUT;
         default: state_in = spcf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      phase_in    = !phase_ff;
      hdr_in      = hdr_ff;
      flen_in     = flen_ff;
      x_in        = x_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      drops_in    = drops_ff;
      queued_in   = queued_ff;
      st_len_in   = st_len_ff;
      pend_in     = pend_ff;
      st_raddr_in = st_raddr_ff;
      st_rok_in   = st_rok_ff;
      mb_we       = 1'b0;
      q_we        = 1'b0;
      st_we       = 1'b0;
      out_ld      = 1'b0;
      rsp_in      = '0;
      unique case (state_ff)
         spcf_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.kind)
                  spcf_pkg::KIND_DATA: begin
                     if (count_ff < CW'(MAILBOX_DEPTH)) begin
                        mb_we    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  spcf_pkg::KIND_END: begin
                     pos_in    = '0;
                     queued_in = '0;
                  end
                  spcf_pkg::KIND_READ: begin
                     st_raddr_in = SAW'(req_chan.read_index);
                     st_rok_in   = (32'(req_chan.read_index) < 32'(st_len_ff)) &&
                                   (32'(req_chan.read_index) < 32'(STAGE_DEPTH));
                  end
                  spcf_pkg::KIND_RELEASE: pend_in = 1'b0;
                  default: ;
               endcase
            end
         end
         spcf_pkg::ST_WSTART: begin
            k_in     = '0;
            phase_in = 1'b0;
         end
         spcf_pkg::ST_WHDR: begin
            if (phase_ff) begin
               hdr_in[k_ff[3:0]] = mb_q_ff;
               k_in              = k_ff + 1'b1;
            end
         end
         spcf_pkg::ST_WEVAL: begin
            priority if (is_sub) begin
               if (!sub_ok) pos_in = pos_ff + 1'b1;
               flen_in  = flen_w;
               k_in     = SW'(2);
               x_in     = '0;
               phase_in = 1'b0;
            end else if (is_cmd) begin
               if (cmd_ok && !full) begin
                  q_we      = 1'b1;
                  head_in   = head_nxt;
                  queued_in = queued_ff + 1'b1;
               end else if (cmd_ok) begin
                  drops_in = drops_ff + 32'd1;
               end
               pos_in = CW'(PW'(pos_ff) + PW'(CMD_HDR_N));
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         spcf_pkg::ST_WSUM: begin
            if (phase_ff) begin
               if (last_byte) begin
                  k_in = '0;
                  if (!((x_ff == mb_q_ff) && !pend_ff))
                     pos_in = CW'(PW'(pos_ff) + PW'(flen_ff));
               end else begin
                  x_in = x_ff ^ mb_q_ff;
                  k_in = k_ff + 1'b1;
               end
            end
         end
         spcf_pkg::ST_WCOPY: begin
            if (phase_ff) begin
               st_we = 1'b1;
               k_in  = k_ff + 1'b1;
               if (last_byte) begin
                  st_len_in = flen_ff;
                  pend_in   = 1'b1;
                  pos_in    = CW'(PW'(pos_ff) + PW'(flen_ff));
               end
            end
         end
         spcf_pkg::ST_WDONE: begin
            if (out_free) begin
               out_ld                  = 1'b1;
               count_in                = '0;
               rsp_in.result_kind      = spcf_pkg::RES_SUMMARY;
               rsp_in.frames_queued    = queued_ff;
               rsp_in.drops_total      = drops_ff;
               rsp_in.subscribe_staged = pend_ff;
               rsp_in.subscribe_length = 9'(st_len_ff);
            end
         end
         spcf_pkg::ST_POP: begin
            if (out_free) begin
               out_ld             = 1'b1;
               rsp_in.result_kind = spcf_pkg::RES_COMMAND;
               if (head_ff == tail_ff) begin
                  rsp_in.queue_empty = 1'b1;
               end else begin
                  rsp_in.cmd_id    = q_q_ff[7:0];
                  rsp_in.cmd_index = q_q_ff[15:8];
                  rsp_in.cmd_value = q_q_ff[47:16];
                  tail_in          = tail_nxt;
               end
            end
         end
         spcf_pkg::ST_RDOUT: begin
            if (out_free) begin
               out_ld             = 1'b1;
               rsp_in.result_kind = spcf_pkg::RES_STAGED;
               rsp_in.staged_byte = st_rok_ff ? st_q_ff : 8'd0;
            end
         end
         spcf_pkg::ST_RDWAIT: ;
         default: ;
      endcase
   end

   assign rsp_valid_in = out_ld || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spcf_pkg::ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         drops_ff     <= '0;
         st_len_ff    <= '0;
         pend_ff      <= 1'b0;
         sub_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         drops_ff     <= drops_in;
         st_len_ff    <= st_len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) sub_en_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      phase_ff    <= phase_in;
      hdr_ff      <= hdr_in;
      flen_ff     <= flen_in;
      x_ff        <= x_in;
      queued_ff   <= queued_in;
      st_raddr_ff <= st_raddr_in;
      st_rok_ff   <= st_rok_in;
      if (out_ld) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mb_we) mb_mem[count_ff[MAW-1:0]] <= req_chan.data_byte;
      mb_q_ff <= mb_mem[mb_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[head_ff] <= {hdr_ff[7], hdr_ff[6], hdr_ff[5], hdr_ff[4],
                                   hdr_ff[3], hdr_ff[2]};
      q_q_ff <= q_mem[tail_ff];
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[k_ff[SAW-1:0]] <= mb_q_ff;
      st_q_ff <= st_mem[st_raddr_ff];
   end

   assign req_chan.ready            = (state_ff == spcf_pkg::ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_kind      = rsp_ff.result_kind;
   assign rsp_chan.cmd_id           = rsp_ff.cmd_id;
   assign rsp_chan.cmd_index        = rsp_ff.cmd_index;
   assign rsp_chan.cmd_value        = rsp_ff.cmd_value;
   assign rsp_chan.queue_empty      = rsp_ff.queue_empty;
   assign rsp_chan.frames_queued    = rsp_ff.frames_queued;
   assign rsp_chan.drops_total      = rsp_ff.drops_total;
   assign rsp_chan.subscribe_staged = rsp_ff.subscribe_staged;
   assign rsp_chan.subscribe_length = rsp_ff.subscribe_length;
   assign rsp_chan.staged_byte      = rsp_ff.staged_byte;

   `SPCF_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(MAILBOX_DEPTH), "mailbox count overflow")
   `SPCF_ASSERT_NXT(a_queue_not_wrapped, q_we, head_ff != tail_ff, "queue write overran tail")
   `SPCF_ASSERT_IMP(a_stage_free, st_we, !pend_ff, "stage written while pending")
   `SPCF_ASSERT_NXT(a_walk_clears, state_ff == spcf_pkg::ST_WDONE && out_ld, count_ff == '0,
                    "byte count not cleared after walk")

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the prefixed command frame parser.
`timescale 1ns / 1ps
class frame_scoreboard;
   logic [7:0]  mbox [256];
   int unsigned nbytes;
   logic [47:0] cq [16];
   int unsigned head, tail;
   logic [31:0] drops;
   logic [7:0]  stage [256];
   int unsigned slen;
   bit          spend;
   bit          sub_en;
   spcf_pkg::rsp_type expected_q[$];
   int          errors;

   function void clear();
      nbytes = 0; head = 0; tail = 0; drops = 0; slen = 0; spend = 0; sub_en = 0;
      errors = 0;
   endfunction

   function int unsigned walk();
      int unsigned pos, q, plen, flen, k, avail, nxt;
      logic [7:0] x;
      bit ok;
      pos = 0; q = 0; avail = nbytes;
      while (pos + 9 <= avail) begin
         if (sub_en && mbox[pos] == spcf_pkg::SYNC_BYTE
             && mbox[pos+1] == spcf_pkg::SUB_BYTE) begin
            plen = {mbox[pos+3], mbox[pos+4]};
            if (mbox[pos+2] == spcf_pkg::SUB_BLOCKS) ok = plen >= 3 && (plen - 3) % 8 == 0;
            else if (mbox[pos+2] == spcf_pkg::SUB_GROUPS) ok = plen % 6 == 0;
            else ok = 0;
            if (!ok || plen > 256 - 7) begin
               pos++;
               continue;
            end
            flen = plen + 7;
            if (pos + flen > avail) break;
            x = 0;
            for (k = 2; k < flen - 1; k++) x ^= mbox[pos+k];
            if (x == mbox[pos+flen-1] && !spend) begin
               for (k = 0; k < flen; k++) stage[k] = mbox[pos+k];
               slen = flen;
               spend = 1;
            end
            pos += flen;
         end else if (mbox[pos] == spcf_pkg::SYNC_BYTE && mbox[pos+1] == spcf_pkg::CMD_BYTE) begin
            x = 0;
            for (k = 2; k < 8; k++) x ^= mbox[pos+k];
            if (x == mbox[pos+8]) begin
               nxt = (head + 1) % 16;
               if (nxt != tail) begin
                  cq[head] = {mbox[pos+7], mbox[pos+6], mbox[pos+5], mbox[pos+4],
                              mbox[pos+3], mbox[pos+2]};
                  head = nxt;
                  q++;
               end else drops++;
            end
            pos += 9;
         end else pos++;
      end
      nbytes = 0;
      return q;
   endfunction

   function void note_request(logic [2:0] kind, logic [7:0] data, logic [7:0] idx);
      spcf_pkg::rsp_type r;
      r = '0;
      case (kind)
         spcf_pkg::KIND_DATA: begin
            if (nbytes < 256) begin
               mbox[nbytes] = data;
               nbytes++;
            end
         end
         spcf_pkg::KIND_END: begin
            r.result_kind = spcf_pkg::RES_SUMMARY;
            r.frames_queued = 5'(walk());
            r.drops_total = drops;
            r.subscribe_staged = spend;
            r.subscribe_length = 9'(slen);
            expected_q.push_back(r);
         end
         spcf_pkg::KIND_POP: begin
            r.result_kind = spcf_pkg::RES_COMMAND;
            if (head == tail) r.queue_empty = 1;
            else begin
               {r.cmd_value, r.cmd_index, r.cmd_id} = cq[tail];
               tail = (tail + 1) % 16;
            end
            expected_q.push_back(r);
         end
         spcf_pkg::KIND_READ: begin
            r.result_kind = spcf_pkg::RES_STAGED;
            if (idx < slen) r.staged_byte = stage[idx];
            expected_q.push_back(r);
         end
         spcf_pkg::KIND_RELEASE: spend = 0;
         default: ;
      endcase
   endfunction

   function void check_result(spcf_pkg::rsp_type got);
      spcf_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
         $display("%0t: mismatch expected %h actual %h", $time, e, got);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic csr_wdata = 0;
   spcf_req_if req_chan ();
   spcf_rsp_if rsp_chan ();
   frame_scoreboard sb;
   int sent;
   int hold_off;
   bit no_idle;
   bit done;
   logic [7:0] fr [$];

   sync_prefixed_command_frame_parser dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.kind = 0;
      req_chan.data_byte = 0;
      req_chan.read_index = 0;
      rsp_chan.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result({rsp_chan.result_kind, rsp_chan.cmd_id, rsp_chan.cmd_index,
                          rsp_chan.cmd_value, rsp_chan.queue_empty, rsp_chan.frames_queued,
                          rsp_chan.drops_total, rsp_chan.subscribe_staged,
                          rsp_chan.subscribe_length, rsp_chan.staged_byte});
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 0;
      end else rsp_chan.ready <= no_idle || $urandom_range(99) >= 30;
   end

   task automatic send(logic [2:0] kind, logic [7:0] data, logic [7:0] idx);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.kind <= kind;
      req_chan.data_byte <= data;
      req_chan.read_index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(kind, data, idx);
      sent++;
   endtask

   task automatic pause_valid();
      req_chan.valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (fr[i]) send(spcf_pkg::KIND_DATA, fr[i], 0);
   endtask

   task automatic make_cmd(bit good);
      logic [7:0] x;
      x = 0;
      fr.push_back(spcf_pkg::SYNC_BYTE);
      fr.push_back(spcf_pkg::CMD_BYTE);
      for (int i = 0; i < 6; i++) begin
         fr.push_back(8'($urandom));
         x ^= fr[fr.size()-1];
      end
      fr.push_back(good ? x : ~x);
   endtask

   task automatic make_sub(bit good, int mode);
      logic [7:0] x;
      int plen;
      logic [7:0] sub;
      x = 0;
      sub = $urandom_range(1) ? spcf_pkg::SUB_GROUPS : spcf_pkg::SUB_BLOCKS;
      plen = sub == spcf_pkg::SUB_GROUPS ? 6 * $urandom_range(0, 4) :
                                           3 + 8 * $urandom_range(0, 3);
      if (mode == 1) plen = sub == spcf_pkg::SUB_GROUPS ? 246 : 243;
      if (mode == 2) plen = plen + 1;
      if (mode == 3) sub = 8'($urandom);
      fr.push_back(spcf_pkg::SYNC_BYTE);
      fr.push_back(spcf_pkg::SUB_BYTE);
      fr.push_back(sub);
      fr.push_back(8'(plen >> 8));
      fr.push_back(8'(plen));
      x = sub ^ 8'(plen >> 8) ^ 8'(plen);
      for (int i = 0; i < plen + 1; i++) begin
         fr.push_back(8'($urandom));
         x ^= fr[fr.size()-1];
      end
      fr.push_back(good ? x : ~x);
   endtask

   task automatic drain();
      pause_valid();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_enable(bit v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.sub_en = v;
      @(posedge clock);
   endtask

   task automatic random_burst();
      int nf, r;
      fr.delete();
      nf = $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) begin
         r = $urandom_range(99);
         if (r < 55) make_cmd($urandom_range(9) != 0);
         else if (r < 75) make_sub($urandom_range(5) != 0, $urandom_range(9) < 7 ? 0 :
                                   $urandom_range(1, 3));
         else repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom));
      end
      if ($urandom_range(9) == 0) fr.delete(fr.size() - 1);
      send_frame();
      send(spcf_pkg::KIND_END, 0, 0);
   endtask

   initial begin
      int r;
      sb = new();
      sb.clear();
      hold_off = 0;
      no_idle = 0;
      sent = 0;
      done = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(spcf_pkg::KIND_POP, 0, 0);
      send(spcf_pkg::KIND_READ, 8'hFF, 8'hFF);
      send(spcf_pkg::KIND_END, 0, 0);
      fr.delete();
      make_cmd(1);
      make_cmd(0);
      fr.push_back(8'h00);
      fr.push_back(8'hFF);
      send_frame();
      send(spcf_pkg::KIND_END, 0, 0);
      send(spcf_pkg::KIND_POP, 0, 0);
      send(spcf_pkg::KIND_POP, 0, 0);
      send(3'd5, 8'hFF, 8'hFF);
      send(3'd7, 0, 0);
      write_enable(1);
      fr.delete();
      make_sub(1, 1);
      send_frame();
      send(spcf_pkg::KIND_END, 0, 0);
      send(spcf_pkg::KIND_READ, 0, 0);
      send(spcf_pkg::KIND_READ, 8'd252, 8'd252);
      send(spcf_pkg::KIND_READ, 8'd253, 8'd253);
      send(spcf_pkg::KIND_RELEASE, 0, 0);
      fr.delete();
      for (int i = 0; i < 29; i++) make_cmd(1);
      send_frame();
      send(spcf_pkg::KIND_END, 0, 0);
      for (int i = 0; i < 300; i++) send(spcf_pkg::KIND_DATA, 8'($urandom), 0);
      send(spcf_pkg::KIND_END, 0, 0);
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) write_enable(ph[0]);
         no_idle = ph == 2;
         if (ph == 1) begin
            hold_off = 400;
            for (int i = 0; i < 12; i++) send(spcf_pkg::KIND_POP, 0, 0);
         end
         while (sent < 380 * (ph + 1) + 20) begin
            r = $urandom_range(99);
            if (r < 40) random_burst();
            else if (r < 70) send(spcf_pkg::KIND_POP, 0, 0);
            else if (r < 88) send(spcf_pkg::KIND_READ, 0, 8'($urandom_range(0, 40)));
            else send(spcf_pkg::KIND_RELEASE, 0, 0);
         end
      end
      drain();
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("PASS sync_prefixed_command_frame_parser");
      else
         $display("FAIL sync_prefixed_command_frame_parser");
      $finish;
   end

   initial begin
      #3000000;
      $display("FAIL sync_prefixed_command_frame_parser");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+src
src/spcf_pkg.sv
src/spcf_if.sv
src/sync_prefixed_command_frame_parser.sv
bench/tb_top.sv
